@@ design/sitrd_pkg.sv @@
// Shared types, constants and a helper function of the signed integer to radix digits unit.
package sitrd_pkg;

  localparam int unsigned MaxBase    = 16;
  localparam int unsigned NumW       = 32;
  localparam int unsigned RadixW     = 5;
  localparam int unsigned CharW      = 8;
  localparam int unsigned AlphaW     = 64;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned AlphaSlots = 16;
  localparam int unsigned MaxDigits  = 32;
  localparam int unsigned DigitIdxW  = 5;
  localparam int unsigned ByteIdxW   = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned FifoDepth  = 2;
  localparam int unsigned FifoPtrW   = 1;
  localparam int unsigned FifoCntW   = 2;

  localparam logic [CfgIdxW-1:0] CfgRadix     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAlphaLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAlphaHigh = 2'd2;

  localparam logic [RadixW-1:0] RadixReset     = 5'd10;
  localparam logic [AlphaW-1:0] AlphaLowReset  = 64'h3736_3534_3332_3130;
  localparam logic [AlphaW-1:0] AlphaHighReset = 64'h0000_0000_0000_3938;

  localparam logic [CharW-1:0] MinusChar = 8'h2D;
  localparam logic [CharW-1:0] PlusChar  = 8'h2B;
  localparam logic [CharW-1:0] BellChar  = 8'h07;
  localparam logic [CharW-1:0] CrChar    = 8'h0D;
  localparam logic [CharW-1:0] SpaceChar = 8'h20;
  localparam logic [CharW-1:0] NulChar   = 8'h00;

  typedef struct packed {
    logic [RadixW-1:0] radix;
    logic [AlphaW-1:0] alpha_low;
    logic [AlphaW-1:0] alpha_high;
  } cfg_t;

  typedef struct packed {
    logic            neg;
    logic [NumW-1:0] mag;
  } item_t;

  function automatic logic [CharW-1:0] glyph(cfg_t cfg, logic [DigitW-1:0] v);
    logic [AlphaW-1:0] word;
    word = v[DigitW-1] ? cfg.alpha_high : cfg.alpha_low;
    return word[{v[DigitW-2:0], 3'b000} +: CharW];
  endfunction

endpackage

@@ design/sitrd_front.sv @@
// Front end: checks the alphabet and turns each number into sign and magnitude.
module sitrd_front (
  input  sitrd_pkg::cfg_t                cfg_i,
  input  logic                           valid_i,
  input  logic [sitrd_pkg::NumW-1:0]     number_i,
  output logic                           ready_o,
  output logic                           push_o,
  output sitrd_pkg::item_t               item_o,
  input  logic                           push_ready_i
);

  logic [sitrd_pkg::CharW-1:0] ch [sitrd_pkg::AlphaSlots];
  logic                        alpha_ok;

  always_comb begin
    for (int i = 0; i < sitrd_pkg::AlphaSlots; i++) begin
      ch[i] = sitrd_pkg::glyph(cfg_i, sitrd_pkg::DigitW'(i));
    end
  end

  always_comb begin
    alpha_ok = (cfg_i.radix >= sitrd_pkg::RadixW'(2)) &&
               (cfg_i.radix <= sitrd_pkg::RadixW'(sitrd_pkg::MaxBase));
    for (int i = 0; i < sitrd_pkg::AlphaSlots; i++) begin
      if (sitrd_pkg::RadixW'(i) < cfg_i.radix) begin
        if (ch[i] == sitrd_pkg::NulChar || ch[i] == sitrd_pkg::MinusChar ||
            ch[i] == sitrd_pkg::PlusChar || ch[i] == sitrd_pkg::SpaceChar ||
            (ch[i] >= sitrd_pkg::BellChar && ch[i] <= sitrd_pkg::CrChar)) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < sitrd_pkg::AlphaSlots; j++) begin
          if (sitrd_pkg::RadixW'(j) < cfg_i.radix && ch[j] == ch[i]) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  // drop the number when the alphabet is unusable
  assign ready_o    = push_ready_i;
  assign push_o     = valid_i && alpha_ok;
  assign item_o.neg = number_i[sitrd_pkg::NumW-1];
  assign item_o.mag = number_i[sitrd_pkg::NumW-1] ? (~number_i + 1'b1) : number_i;

endmodule

@@ design/sitrd_fifo.sv @@
// Short queue of classified numbers between front and back end.
module sitrd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sitrd_pkg::item_t push_item_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output sitrd_pkg::item_t pop_item_o,
  input  logic             pop_i
);

  sitrd_pkg::item_t                   mem_q [sitrd_pkg::FifoDepth];
  logic [sitrd_pkg::FifoPtrW-1:0]     wr_ptr_q;
  logic [sitrd_pkg::FifoPtrW-1:0]     rd_ptr_q;
  logic [sitrd_pkg::FifoCntW-1:0]     cnt_q;
  logic                               do_push;
  logic                               do_pop;

  assign push_ready_o = (cnt_q != sitrd_pkg::FifoCntW'(sitrd_pkg::FifoDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ design/sitrd_back.sv @@
// Back end: divides the magnitude down into digits, then sends sign and digits out.
module sitrd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sitrd_pkg::cfg_t              cfg_i,
  input  logic                         pop_valid_i,
  input  sitrd_pkg::item_t             pop_item_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  output logic [sitrd_pkg::CharW-1:0]  out_char_o,
  output logic                         out_last_o,
  input  logic                         out_ready_i
);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StEmit
  } state_e;

  state_e                           state_q;
  logic [sitrd_pkg::NumW-1:0]       mag_q;
  logic [sitrd_pkg::NumW-1:0]       quo_q;
  logic [sitrd_pkg::DigitW-1:0]     rem_q;
  logic [sitrd_pkg::ByteIdxW-1:0]   byte_q;
  logic [sitrd_pkg::DigitIdxW-1:0]  cnt_q;
  logic                             sign_q;
  logic [sitrd_pkg::DigitW-1:0]     dig_q [sitrd_pkg::MaxDigits];
  logic                             out_valid_q;
  logic [sitrd_pkg::CharW-1:0]      out_char_q;
  logic                             out_last_q;

  logic [sitrd_pkg::CharW-1:0]      cur_byte;
  logic [sitrd_pkg::CharW-1:0]      qbits;
  logic [sitrd_pkg::DigitW-1:0]     rem_d;
  logic [sitrd_pkg::NumW-1:0]       quo_d;
  logic [sitrd_pkg::DigitW:0]       trial;
  logic                             out_load;
  logic                             digit_done;

  function automatic logic [sitrd_pkg::ByteIdxW-1:0] top_byte(logic [sitrd_pkg::NumW-1:0] v);
    logic [sitrd_pkg::ByteIdxW-1:0] idx;
    idx = '0;
    for (int b = 1; b < sitrd_pkg::NumW / 8; b++) begin
      if (v[b*8 +: 8] != '0) begin
        idx = sitrd_pkg::ByteIdxW'(b);
      end
    end
    return idx;
  endfunction

  // restoring division of one dividend byte by the radix
  always_comb begin
    cur_byte = mag_q[{byte_q, 3'b000} +: sitrd_pkg::CharW];
    rem_d    = rem_q;
    qbits    = '0;
    trial    = '0;
    for (int k = sitrd_pkg::CharW - 1; k >= 0; k--) begin
      trial = {rem_d, cur_byte[k]};
      if (trial >= cfg_i.radix) begin
        trial    = trial - cfg_i.radix;
        qbits[k] = 1'b1;
      end
      rem_d = trial[sitrd_pkg::DigitW-1:0];
    end
    quo_d = {quo_q[sitrd_pkg::NumW-sitrd_pkg::CharW-1:0], qbits};
  end

  assign digit_done  = (state_q == StDiv) && (byte_q == '0);
  assign out_load    = !out_valid_q || out_ready_i;
  assign pop_o       = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i) begin
    if (digit_done) begin
      dig_q[cnt_q] <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mag_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      byte_q      <= '0;
      cnt_q       <= '0;
      sign_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_ready_i && state_q != StEmit) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (pop_valid_i) begin
            mag_q   <= pop_item_i.mag;
            sign_q  <= pop_item_i.neg;
            quo_q   <= '0;
            rem_q   <= '0;
            byte_q  <= top_byte(pop_item_i.mag);
            cnt_q   <= '0;
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (byte_q == '0) begin
            quo_q  <= '0;
            rem_q  <= '0;
            mag_q  <= quo_d;
            byte_q <= top_byte(quo_d);
            if (quo_d == '0) begin
              state_q <= StEmit;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end else begin
            quo_q  <= quo_d;
            rem_q  <= rem_d;
            byte_q <= byte_q - 1'b1;
          end
        end
        StEmit: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            if (sign_q) begin
              out_char_q <= sitrd_pkg::MinusChar;
              out_last_q <= 1'b0;
              sign_q     <= 1'b0;
            end else begin
              out_char_q <= sitrd_pkg::glyph(cfg_i, dig_q[cnt_q]);
              out_last_q <= (cnt_q == '0);
              if (cnt_q == '0) begin
                state_q <= StIdle;
              end else begin
                cnt_q <= cnt_q - 1'b1;
              end
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

@@ design/signed_integer_to_radix_digits_unit.sv @@
// Top level of the signed integer to radix digits unit.
// Each number accepted on the slave stream comes out on the master stream as a minus sign for
// negative values followed by its digits in the configured radix, most significant first, with
// tlast on the last digit; numbers taken while the alphabet is invalid give no characters. A
// two-entry queue sits between the input stage and the converter, so the input keeps taking
// numbers while the converter works. The converter handles one number at a time: it loads the
// number, then forms each digit by dividing the running quotient byte by byte over its significant
// bytes (one to four), then sends the characters out as the sink takes them. Configuration writes
// take effect at the next clock edge and must only be made while no number is in flight.
module signed_integer_to_radix_digits_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sitrd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [sitrd_pkg::AlphaW-1:0]      cfg_wdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [sitrd_pkg::NumW-1:0]        s_axis_tdata_i,   // [31:0] number
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [sitrd_pkg::CharW-1:0]       m_axis_tdata_o,   // [7:0] out_char
  output logic                              m_axis_tlast_o    // final_char
);

  sitrd_pkg::cfg_t  cfg_q;
  sitrd_pkg::item_t push_item;
  sitrd_pkg::item_t pop_item;
  logic             push;
  logic             push_ready;
  logic             pop_valid;
  logic             pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radix      <= sitrd_pkg::RadixReset;
      cfg_q.alpha_low  <= sitrd_pkg::AlphaLowReset;
      cfg_q.alpha_high <= sitrd_pkg::AlphaHighReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sitrd_pkg::CfgRadix:     cfg_q.radix      <= cfg_wdata_i[sitrd_pkg::RadixW-1:0];
        sitrd_pkg::CfgAlphaLow:  cfg_q.alpha_low  <= cfg_wdata_i;
        sitrd_pkg::CfgAlphaHigh: cfg_q.alpha_high <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  sitrd_front u_front (
    .cfg_i        (cfg_q),
    .valid_i      (s_axis_tvalid_i),
    .number_i     (s_axis_tdata_i),
    .ready_o      (s_axis_tready_o),
    .push_o       (push),
    .item_o       (push_item),
    .push_ready_i (push_ready)
  );

  sitrd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_i        (pop)
  );

  sitrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_char_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_ready_i (m_axis_tready_i)
  );

endmodule

@@ design/sitrd_checker.sv @@
// Port-level checks of the signed integer to radix digits unit and their binding.
module sitrd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [sitrd_pkg::CharW-1:0]       m_axis_tdata_o,
  input logic                              m_axis_tlast_o
);

  // hold a stalled output transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output transfer changed while stalled");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o && s_axis_tready_o)
    else $error("outputs not idle after reset");

  // the input side only fills up after taking a transfer
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("input ready dropped without a transfer");

endmodule

bind signed_integer_to_radix_digits_unit sitrd_checker u_sitrd_checker (.*);
